FILE: hw/rtl/ckt_pkg.sv
// ----------------------------------------------------------------------------
// ckt_pkg
// Shared types and constants of the compacting keyed table: capacity, key
// width, operation and status codes, entry and control structs.
// ----------------------------------------------------------------------------
package ckt_pkg;

  // table size and key width
  localparam int CAPACITY = 16;
  localparam int KEY_BITS = 64;

  // derived widths
  localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int FILL_W = $clog2(CAPACITY + 1);

  // operation codes
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_MISS  = 2'd3
  } status_t;

  // sequencer states
  typedef enum logic {
    SM_IDLE = 1'b0,
    SM_RUN  = 1'b1
  } state_t;

  // one stored entry
  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [63:0]         kind;
    logic [31:0]         qty;
  } entry_t;

  // latched request
  typedef struct packed {
    op_t    op;
    entry_t ent;
  } cmd_t;

  // per-cell control from the sequencer
  typedef struct packed {
    logic go;
    logic live;
    logic at_tail;
  } cell_ctl_t;

endpackage

FILE: hw/rtl/ckt_cell.sv
// ----------------------------------------------------------------------------
// ckt_cell
// One slot of the table: holds an entry, compares its key against the
// request, extends the first-match chain and loads either a new entry on
// insert or its right neighbor's entry on a compacting remove.
// ----------------------------------------------------------------------------
module ckt_cell (
  input  logic               clk,
  input  ckt_pkg::cmd_t      cmd,
  input  ckt_pkg::cell_ctl_t ctl,
  input  logic               seen_in,
  input  ckt_pkg::entry_t    nxt_ent,
  output logic               seen_out,
  output logic               first,
  output ckt_pkg::entry_t    ent
);
  import ckt_pkg::*;

  logic match;

  // key compare and first-match chain
  assign match    = ctl.live && (ent.key == cmd.ent.key);
  assign seen_out = seen_in | match;
  assign first    = match & ~seen_in;

  // append at the tail, or shift down from the removed slot onward
  always_ff @(posedge clk) begin
    if (ctl.go) begin
      if (cmd.op == OP_INSERT && ctl.at_tail) begin
        ent <= cmd.ent;
      end else if (cmd.op == OP_REMOVE && seen_out) begin
        ent <= nxt_ent;
      end
    end
  end

endmodule

FILE: hw/rtl/compacting_keyed_table.sv
// ----------------------------------------------------------------------------
// compacting_keyed_table
// Fixed-capacity ordered table of key / kind / quantity entries with append,
// remove-with-compaction and first-match lookup, built as a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   A request (op, item_key, item_kind, item_count) is taken at a rising edge
//   with start high and busy low. busy is high for the one cycle in which
//   every cell compares its key, the first-match chain settles and the cells
//   append or shift down. The result (status, hit_index, hit_kind, hit_count,
//   fill_level) is shown with done high for exactly one cycle, starting in
//   the cycle after the busy cycle, and is taken at the edge that ends it;
//   the receiver cannot hold it off.
//   A new request is accepted in the cycle done is high; none is taken
//   while busy is high. Each request makes a single compare and shift pass
//   through the cell row, which sees the whole table at once.
//   Reset (rst, synchronous) empties the table and clears busy and done;
//   entry contents are not cleared, as slots beyond the fill count are
//   never read. Keys compare on their low KEY_BITS bits.
// ----------------------------------------------------------------------------
module compacting_keyed_table (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         op,
  input  logic [63:0]        item_key,
  input  logic [63:0]        item_kind,
  input  logic signed [31:0] item_count,
  output logic               done,
  output logic [1:0]         status,
  output logic [3:0]         hit_index,
  output logic [63:0]        hit_kind,
  output logic signed [31:0] hit_count,
  output logic [4:0]         fill_level
);
  import ckt_pkg::*;

  state_t            state;
  state_t            state_next;
  cmd_t              cmd;
  logic              cmd_load;
  logic [FILL_W-1:0] used;
  logic [FILL_W-1:0] used_next;

  entry_t            ent     [CAPACITY];
  entry_t            nxt_ent [CAPACITY];
  cell_ctl_t         ctl     [CAPACITY];
  logic [CAPACITY:0] seen;
  logic [CAPACITY-1:0] first;

  logic              any_hit;
  logic [IDX_W-1:0]  hit_idx;
  entry_t            hit_ent;

  status_t           status_next;
  logic [3:0]        hit_index_next;
  logic [63:0]       hit_kind_next;
  logic [31:0]       hit_count_next;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      SM_IDLE: if (start) state_next = SM_RUN;
      SM_RUN:  state_next = SM_IDLE;
      default: state_next = SM_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    busy     = 1'b0;
    cmd_load = 1'b0;
    case (state)
      SM_IDLE: cmd_load = start;
      SM_RUN:  busy = 1'b1;
      default: busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // latch the request
  always_ff @(posedge clk) begin
    if (cmd_load) begin
      cmd.op      <= op_t'(op);
      cmd.ent.key <= item_key[KEY_BITS-1:0];
      cmd.ent.kind <= item_kind;
      cmd.ent.qty <= item_count;
    end
  end

  // row of cells
  assign seen[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign ctl[i].go      = (state == SM_RUN);
    assign ctl[i].live    = (FILL_W'(i) < used);
    assign ctl[i].at_tail = (FILL_W'(i) == used);

    if (i == CAPACITY - 1) begin : g_last
      assign nxt_ent[i] = ent[i];
    end else begin : g_mid
      assign nxt_ent[i] = ent[i+1];
    end

    ckt_cell u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .ctl      (ctl[i]),
      .seen_in  (seen[i]),
      .nxt_ent  (nxt_ent[i]),
      .seen_out (seen[i+1]),
      .first    (first[i]),
      .ent      (ent[i])
    );
  end

  assign any_hit = seen[CAPACITY];

  // encode first-match position and select its entry
  always_comb begin
    hit_idx = '0;
    hit_ent = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
        hit_ent = hit_ent | ent[i];
      end
    end
  end

  // result and fill count
  always_comb begin
    status_next    = ST_OK;
    hit_index_next = '0;
    hit_kind_next  = '0;
    hit_count_next = '0;
    used_next      = used;
    case (cmd.op)
      OP_INSERT: begin
        if (used == FILL_W'(CAPACITY)) begin
          status_next = ST_FULL;
        end else begin
          hit_index_next = 4'(used);
          used_next      = used + FILL_W'(1);
        end
      end
      OP_REMOVE, OP_LOOKUP: begin
        if (used == '0) begin
          status_next = ST_EMPTY;
        end else if (!any_hit) begin
          status_next = ST_MISS;
        end else begin
          hit_index_next = 4'(hit_idx);
          if (cmd.op == OP_REMOVE) begin
            used_next = used - FILL_W'(1);
          end else begin
            hit_kind_next  = hit_ent.kind;
            hit_count_next = hit_ent.qty;
          end
        end
      end
      default: begin
        used_next = used;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      done <= 1'b0;
    end else begin
      done <= (state == SM_RUN);
      if (state == SM_RUN) begin
        used <= used_next;
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (state == SM_RUN) begin
      status     <= status_next;
      hit_index  <= hit_index_next;
      hit_kind   <= hit_kind_next;
      hit_count  <= hit_count_next;
      fill_level <= 5'(used_next);
    end
  end

  // checks
  a_done_after_run: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == SM_RUN))
    else $error("done without a compare pass");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    used <= FILL_W'(CAPACITY))
    else $error("fill count above capacity");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  a_miss_keeps_fill: assert property (@(posedge clk) disable iff (rst)
    (state == SM_RUN) && !any_hit && (cmd.op != OP_INSERT) |=> used == $past(used))
    else $error("fill count changed without a match");

endmodule
